[hw/rtl/cas_pkg.sv]
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants for the Costas array search core.
// ----------------------------------------------------------------------------
package cas_pkg;

    // Largest supported array order (default of the top-level parameter)
    localparam int CAS_MAX_ORDER = 16;

    // Order register: width and value after reset
    localparam int          CAS_ORDER_W     = 5;
    localparam logic [4:0]  CAS_ORDER_RESET = 5'd13;

    // Result field widths
    localparam int CAS_POS_W = 4;
    localparam int CAS_VAL_W = 4;

endpackage

[hw/rtl/cas_perm_mem.sv]
// ----------------------------------------------------------------------------
// cas_perm_mem
// Permutation store: two registered read ports, one write port. Entries that
// were not written since the last clear read back as their own index.
// ----------------------------------------------------------------------------
module cas_perm_mem #(
    parameter int MAX_ORDER = cas_pkg::CAS_MAX_ORDER,
    parameter int AW        = $clog2(MAX_ORDER)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_ra_en,
    input  logic [AW-1:0] i_ra_addr,
    output logic [AW-1:0] o_ra_data,
    input  logic          i_rb_en,
    input  logic [AW-1:0] i_rb_addr,
    output logic [AW-1:0] o_rb_data,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wdata
);

    logic [AW-1:0]        r_mem [MAX_ORDER];
    logic [MAX_ORDER-1:0] r_written;
    logic [AW-1:0]        r_qa;
    logic [AW-1:0]        r_qb;
    logic [AW-1:0]        r_ia;
    logic [AW-1:0]        r_ib;
    logic                 r_va;
    logic                 r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ra_en) begin
            r_qa <= r_mem[i_ra_addr];
            r_ia <= i_ra_addr;
            r_va <= r_written[i_ra_addr];
        end
        if (i_rb_en) begin
            r_qb <= r_mem[i_rb_addr];
            r_ib <= i_rb_addr;
            r_vb <= r_written[i_rb_addr];
        end
    end

    // Written flags: clear on reset and on search restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_written <= '0;
        end else if (i_we) begin
            r_written[i_waddr] <= 1'b1;
        end
    end

    assign o_ra_data = r_va ? r_qa : r_ia;
    assign o_rb_data = r_vb ? r_qb : r_ib;

endmodule

[hw/rtl/cas_diff_mem.sv]
// ----------------------------------------------------------------------------
// cas_diff_mem
// Difference table: one write port, one registered read port, addressed by
// {earlier column, distance}.
// ----------------------------------------------------------------------------
module cas_diff_mem #(
    parameter int MAX_ORDER = cas_pkg::CAS_MAX_ORDER,
    parameter int AW        = $clog2(MAX_ORDER),
    parameter int DW        = AW + 1
) (
    input  logic            i_clk,
    input  logic            i_re,
    input  logic [2*AW-1:0] i_raddr,
    output logic [DW-1:0]   o_rdata,
    input  logic            i_we,
    input  logic [2*AW-1:0] i_waddr,
    input  logic [DW-1:0]   i_wdata
);

    localparam int Depth = 1 << (2 * AW);

    logic [DW-1:0] r_mem [Depth];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

[hw/rtl/costas_array_search_core.sv]
// ----------------------------------------------------------------------------
// costas_array_search_core
// Depth-first enumeration of Costas permutations with an explicit per-level
// stack; each request transfers the next solution, one element per result.
// ----------------------------------------------------------------------------
//
//  channel | signals                                 | transfer when
//  --------+-----------------------------------------+------------------------
//  request | i_in_valid, o_in_ready, i_restart       | i_in_valid & o_in_ready
//  result  | o_out_valid, i_out_ready, o_position,   | o_out_valid &
//          | o_value, o_last, o_exhausted            |   i_out_ready
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_order   | i_cfg_valid & o_cfg_ready
//
// Search: a request runs a search of data-dependent length. Testing one
// candidate at level L is paced by the single read port of the difference
// memory; a backtrack or descent swap runs through states SW1 and SW2.
// Each solution element is read in ORD and loaded into the result register in OLD.
// Reset: synchronous, active low; order returns to 13 and the search to the
// identity permutation. No clearing pass is needed.
// Stalls: requests and config writes are taken only between searches; a
// stalled result holds the sequencer, the final result does not.
//
module costas_array_search_core #(
    parameter int MAX_ORDER = cas_pkg::CAS_MAX_ORDER
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_restart,
    // result
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cas_pkg::CAS_POS_W-1:0] o_position,
    output logic [cas_pkg::CAS_VAL_W-1:0] o_value,
    output logic                        o_last,
    output logic                        o_exhausted,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cas_pkg::CAS_ORDER_W-1:0] i_cfg_order
);

    localparam int AW = $clog2(MAX_ORDER);      // column / value index
    localparam int LW = $clog2(MAX_ORDER + 1);  // counts up to the order
    localparam int DW = AW + 1;                 // signed difference
    localparam int OW = cas_pkg::CAS_ORDER_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_TOP  = 4'd1;
    localparam logic [3:0] ST_BK   = 4'd2;
    localparam logic [3:0] ST_PC   = 4'd3;
    localparam logic [3:0] ST_DIFF = 4'd4;
    localparam logic [3:0] ST_CMP  = 4'd5;
    localparam logic [3:0] ST_ACC  = 4'd6;
    localparam logic [3:0] ST_SW1  = 4'd7;
    localparam logic [3:0] ST_SW2  = 4'd8;
    localparam logic [3:0] ST_ORD  = 4'd9;
    localparam logic [3:0] ST_OLD  = 4'd10;
    localparam logic [3:0] ST_EXH  = 4'd11;

    localparam logic [OW:0] MaxOrd = (OW + 1)'(MAX_ORDER);

    // Control state
    logic [3:0]    r_state, n_state;
    logic [OW-1:0] r_order, n_order;
    logic          r_fin,   n_fin;
    logic [AW-1:0] r_lvl,   n_lvl;
    logic [LW-1:0] r_cand [MAX_ORDER];
    logic [LW-1:0] n_cand [MAX_ORDER];
    logic          r_ovld,  n_ovld;
    // Work registers
    logic [LW-1:0] r_c,    n_c;
    logic [AW-1:0] r_pc,   n_pc;
    logic [AW-1:0] r_i,    n_i;
    logic [AW-1:0] r_j,    n_j;
    logic [DW-1:0] r_diff, n_diff;
    logic [AW-1:0] r_swc,  n_swc;
    logic [AW-1:0] r_swl,  n_swl;
    logic [AW-1:0] r_tmp,  n_tmp;
    logic [AW-1:0] r_k,    n_k;
    logic [cas_pkg::CAS_POS_W-1:0] r_opos, n_opos;
    logic [cas_pkg::CAS_VAL_W-1:0] r_oval, n_oval;
    logic          r_olast, n_olast;
    logic          r_oexh,  n_oexh;

    // Memory ports
    logic          w_clear;
    logic          w_ra_en, w_rb_en, w_pwe;
    logic [AW-1:0] w_ra_addr, w_rb_addr, w_pwaddr, w_pwdata;
    logic [AW-1:0] w_ra_data, w_rb_data;
    logic          w_dre, w_dwe;
    logic [2*AW-1:0] w_draddr, w_dwaddr;
    logic [DW-1:0] w_drdata, w_dwdata;

    logic [LW-1:0] w_n;
    logic [LW-1:0] w_nm1;
    logic [LW-1:0] w_c;
    logic [AW-1:0] w_d;
    logic          w_in_xfer, w_cfg_xfer, w_out_free;

    // Effective order: zero acts as one, anything above the maximum clamps
    always_comb begin
        if (r_order == '0) begin
            w_n = LW'(1);
        end else if ({1'b0, r_order} > MaxOrd) begin
            w_n = LW'(MAX_ORDER);
        end else begin
            w_n = LW'(r_order);
        end
    end

    assign w_nm1      = w_n - LW'(1);
    assign w_c        = r_cand[r_lvl];
    assign w_d        = r_lvl - r_i;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_ovld || i_out_ready;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_ovld;
    assign o_position  = r_opos;
    assign o_value     = r_oval;
    assign o_last      = r_olast;
    assign o_exhausted = r_oexh;

    always_comb begin
        n_state = r_state;
        n_order = r_order;
        n_fin   = r_fin;
        n_lvl   = r_lvl;
        n_cand  = r_cand;
        n_ovld  = r_ovld && !i_out_ready;
        n_c     = r_c;
        n_pc    = r_pc;
        n_i     = r_i;
        n_j     = r_j;
        n_diff  = r_diff;
        n_swc   = r_swc;
        n_swl   = r_swl;
        n_tmp   = r_tmp;
        n_k     = r_k;
        n_opos  = r_opos;
        n_oval  = r_oval;
        n_olast = r_olast;
        n_oexh  = r_oexh;

        w_clear   = 1'b0;
        w_ra_en   = 1'b0;
        w_ra_addr = '0;
        w_rb_en   = 1'b0;
        w_rb_addr = '0;
        w_pwe     = 1'b0;
        w_pwaddr  = '0;
        w_pwdata  = '0;
        w_dre     = 1'b0;
        w_draddr  = '0;
        w_dwe     = 1'b0;
        w_dwaddr  = '0;
        w_dwdata  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_cfg_xfer) begin
                    n_order = i_cfg_order;
                end
                // Restart: identity permutation, level zero, first slot
                if (w_cfg_xfer || (w_in_xfer && i_restart)) begin
                    w_clear   = 1'b1;
                    n_cand[0] = '0;
                    n_lvl     = '0;
                    n_fin     = 1'b0;
                end
                if (w_in_xfer) begin
                    if (r_fin && !w_cfg_xfer && !i_restart) begin
                        n_state = ST_EXH;
                    end else begin
                        n_state = ST_TOP;
                    end
                end
            end
            ST_TOP: begin
                if (w_c >= w_n) begin
                    if (r_lvl == '0) begin
                        n_fin   = 1'b1;
                        n_state = ST_EXH;
                    end else begin
                        // drop back one level, then undo its swap
                        n_lvl   = r_lvl - AW'(1);
                        n_state = ST_BK;
                    end
                end else begin
                    n_c       = w_c;
                    w_ra_en   = 1'b1;
                    w_ra_addr = AW'(w_c);
                    n_state   = ST_PC;
                end
            end
            ST_BK: begin
                w_ra_en        = 1'b1;
                w_ra_addr      = AW'(w_c);
                w_rb_en        = 1'b1;
                w_rb_addr      = r_lvl;
                n_swc          = AW'(w_c);
                n_swl          = r_lvl;
                n_cand[r_lvl]  = w_c + LW'(1);
                n_state        = ST_SW1;
            end
            ST_PC: begin
                n_pc = w_ra_data;
                n_i  = '0;
                if (r_lvl == '0) begin
                    n_state = ST_ACC;
                end else begin
                    w_rb_en   = 1'b1;
                    w_rb_addr = '0;
                    n_state   = ST_DIFF;
                end
            end
            ST_DIFF: begin
                // store the new difference against column i at distance lvl-i
                n_diff   = {1'b0, r_pc} - {1'b0, w_rb_data};
                w_dwe    = 1'b1;
                w_dwaddr = {r_i, w_d};
                w_dwdata = {1'b0, r_pc} - {1'b0, w_rb_data};
                if (r_i == '0) begin
                    if (r_lvl == AW'(1)) begin
                        n_state = ST_ACC;
                    end else begin
                        n_i       = AW'(1);
                        w_rb_en   = 1'b1;
                        w_rb_addr = AW'(1);
                    end
                end else begin
                    w_dre    = 1'b1;
                    w_draddr = {AW'(0), w_d};
                    n_j      = AW'(1);
                    n_state  = ST_CMP;
                end
            end
            ST_CMP: begin
                if (w_drdata == r_diff) begin
                    // repeated difference: reject, try the next slot
                    n_cand[r_lvl] = r_c + LW'(1);
                    n_state       = ST_TOP;
                end else if (r_j < r_i) begin
                    w_dre    = 1'b1;
                    w_draddr = {r_j, w_d};
                    n_j      = r_j + AW'(1);
                end else if (r_i + AW'(1) == r_lvl) begin
                    n_state = ST_ACC;
                end else begin
                    n_i       = r_i + AW'(1);
                    w_rb_en   = 1'b1;
                    w_rb_addr = r_i + AW'(1);
                    n_state   = ST_DIFF;
                end
            end
            ST_ACC: begin
                if (LW'(r_lvl) == w_nm1) begin
                    n_cand[r_lvl] = r_c + LW'(1);
                    n_k           = '0;
                    n_state       = ST_ORD;
                end else begin
                    // descend: swap the slot into this column
                    n_cand[r_lvl]            = r_c;
                    n_cand[r_lvl + AW'(1)]   = LW'(r_lvl) + LW'(1);
                    n_lvl                    = r_lvl + AW'(1);
                    n_swc                    = AW'(r_c);
                    n_swl                    = r_lvl;
                    w_ra_en                  = 1'b1;
                    w_ra_addr                = AW'(r_c);
                    w_rb_en                  = 1'b1;
                    w_rb_addr                = r_lvl;
                    n_state                  = ST_SW1;
                end
            end
            ST_SW1: begin
                w_pwe    = 1'b1;
                w_pwaddr = r_swl;
                w_pwdata = w_ra_data;
                n_tmp    = w_rb_data;
                n_state  = ST_SW2;
            end
            ST_SW2: begin
                w_pwe    = 1'b1;
                w_pwaddr = r_swc;
                w_pwdata = r_tmp;
                n_state  = ST_TOP;
            end
            ST_ORD: begin
                w_ra_en   = 1'b1;
                w_ra_addr = r_k;
                n_state   = ST_OLD;
            end
            ST_OLD: begin
                if (w_out_free) begin
                    n_ovld  = 1'b1;
                    n_opos  = cas_pkg::CAS_POS_W'(r_k);
                    n_oval  = cas_pkg::CAS_VAL_W'(w_ra_data);
                    n_olast = (LW'(r_k) == w_nm1);
                    n_oexh  = 1'b0;
                    if (LW'(r_k) == w_nm1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = ST_ORD;
                    end
                end
            end
            ST_EXH: begin
                if (w_out_free) begin
                    n_ovld  = 1'b1;
                    n_opos  = '0;
                    n_oval  = '0;
                    n_olast = 1'b1;
                    n_oexh  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Deeper stack entries are always written before they are read; only the
    // bottom entry needs a reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_order   <= cas_pkg::CAS_ORDER_RESET;
            r_fin     <= 1'b0;
            r_lvl     <= '0;
            r_ovld    <= 1'b0;
            r_cand[0] <= '0;
        end else begin
            r_state   <= n_state;
            r_order   <= n_order;
            r_fin     <= n_fin;
            r_lvl     <= n_lvl;
            r_ovld    <= n_ovld;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_cand[k] <= n_cand[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_pc    <= n_pc;
        r_i     <= n_i;
        r_j     <= n_j;
        r_diff  <= n_diff;
        r_swc   <= n_swc;
        r_swl   <= n_swl;
        r_tmp   <= n_tmp;
        r_k     <= n_k;
        r_opos  <= n_opos;
        r_oval  <= n_oval;
        r_olast <= n_olast;
        r_oexh  <= n_oexh;
    end

    cas_perm_mem #(
        .MAX_ORDER (MAX_ORDER),
        .AW        (AW)
    ) u_perm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_ra_en   (w_ra_en),
        .i_ra_addr (w_ra_addr),
        .o_ra_data (w_ra_data),
        .i_rb_en   (w_rb_en),
        .i_rb_addr (w_rb_addr),
        .o_rb_data (w_rb_data),
        .i_we      (w_pwe),
        .i_waddr   (w_pwaddr),
        .i_wdata   (w_pwdata)
    );

    cas_diff_mem #(
        .MAX_ORDER (MAX_ORDER),
        .AW        (AW),
        .DW        (DW)
    ) u_diff (
        .i_clk   (i_clk),
        .i_re    (w_dre),
        .i_raddr (w_draddr),
        .o_rdata (w_drdata),
        .i_we    (w_dwe),
        .i_waddr (w_dwaddr),
        .i_wdata (w_dwdata)
    );

endmodule

[tb/costas_array_search_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// costas_array_search_core_tb
// Self-checking bench for the Costas search core. A directed table covers
// tiny orders, exhaustion, restart and out-of-range order writes; random
// phases then enumerate small orders under random idling on both channels.
// Each result transfer is checked against a model of the backtracking search or a hand-typed row.
// ----------------------------------------------------------------------------
module costas_array_search_core_tb;

    localparam int NMAX     = cas_pkg::CAS_MAX_ORDER;
    localparam int WDOG_MAX = 2000000;
    localparam int RND_REQS = 480;

    typedef struct packed {
        logic [cas_pkg::CAS_POS_W-1:0] pos;
        logic [cas_pkg::CAS_VAL_W-1:0] val;
        logic                          last;
        logic                          exh;
    } t_elem;

    // one row of the directed table: optional order write, optional request,
    // optional hand-typed single result
    typedef struct {
        bit                              do_cfg;
        logic [cas_pkg::CAS_ORDER_W-1:0] cfg_val;
        bit                              do_req;
        bit                              restart;
        bit                              typed;
        t_elem                           typed_res;
    } t_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic                            i_restart = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [cas_pkg::CAS_POS_W-1:0]   o_position;
    logic [cas_pkg::CAS_VAL_W-1:0]   o_value;
    logic                            o_last;
    logic                            o_exhausted;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [cas_pkg::CAS_ORDER_W-1:0] i_cfg_order = '0;

    costas_array_search_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_position  (o_position),
        .o_value     (o_value),
        .o_last      (o_last),
        .o_exhausted (o_exhausted),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_order (i_cfg_order)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Search model: own copy of permutation stack and difference table
    // ------------------------------------------------------------------
    logic [cas_pkg::CAS_ORDER_W-1:0] mdl_order;
    logic [3:0]             mdl_perm [NMAX];
    int                     mdl_diff [NMAX*NMAX];
    int                     mdl_cand [NMAX];
    int                     mdl_level;
    bit                     mdl_done;

    t_elem solution_q [$];   // expected result transfers, oldest first

    int  errors     = 0;
    int  n_req      = 0;
    int  n_res      = 0;
    int  n_exh      = 0;
    int  n_cfg      = 0;
    int  n_sol_max  = 0;
    bit  quiet      = 0;     // no idling in the final stretch

    function automatic int clamp_order();
        if (mdl_order < 1) return 1;
        if (mdl_order > NMAX) return NMAX;
        return int'(mdl_order);
    endfunction

    task automatic restart_search();
        for (int k = 0; k < NMAX; k++) begin
            mdl_perm[k] = k[3:0];
            mdl_cand[k] = 0;
        end
        for (int k = 0; k < NMAX*NMAX; k++) mdl_diff[k] = 0;
        mdl_level = 0;
        mdl_done  = 0;
    endtask

    task automatic swap_cols(input int a, input int b);
        logic [3:0] t;
        t = mdl_perm[a];
        mdl_perm[a] = mdl_perm[b];
        mdl_perm[b] = t;
    endtask

    // store the differences of the candidate; reject on the first repeat
    function automatic bit fits(input int lv, input int c);
        int d;
        int df;
        for (int i = 0; i < lv; i++) begin
            d  = lv - i;
            df = int'(mdl_perm[c]) - int'(mdl_perm[i]);
            mdl_diff[i*NMAX + d] = df;
            for (int j = 0; j < i; j++)
                if (mdl_diff[j*NMAX + d] == df) return 0;
        end
        return 1;
    endfunction

    task automatic next_solution(output bit found);
        int n;
        int lv;
        int c;
        n = clamp_order();
        forever begin
            lv = mdl_level;
            c  = mdl_cand[lv];
            if (c >= n) begin
                if (lv == 0) begin
                    mdl_done = 1;
                    found = 0;
                    return;
                end
                lv--;
                mdl_level = lv;
                c = mdl_cand[lv];
                swap_cols(c, lv);
                mdl_cand[lv] = c + 1;
            end else if (!fits(lv, c)) begin
                mdl_cand[lv] = c + 1;
            end else if (lv == n - 1) begin
                mdl_cand[lv] = c + 1;
                found = 1;
                return;
            end else begin
                swap_cols(c, lv);
                mdl_cand[lv] = c;
                mdl_level = lv + 1;
                mdl_cand[lv + 1] = lv + 1;
            end
        end
    endtask

    // advance the model for one request; queue the predicted transfers
    task automatic predict_request(input bit restart, input bit typed, input t_elem tres);
        bit    found;
        int    n;
        t_elem e;
        if (restart) restart_search();
        found = 0;
        if (!mdl_done) next_solution(found);
        n = clamp_order();
        if (typed) begin
            solution_q.push_back(tres);
        end else if (!found) begin
            e = '{pos: '0, val: '0, last: 1'b1, exh: 1'b1};
            solution_q.push_back(e);
        end else begin
            for (int k = 0; k < n; k++) begin
                e.pos  = k[3:0];
                e.val  = mdl_perm[k];
                e.last = (k == n - 1);
                e.exh  = 1'b0;
                solution_q.push_back(e);
            end
        end
        if (found && n > n_sol_max) n_sol_max = n;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(input bit restart, input bit typed, input t_elem tres);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        // hold until the core takes the request
        do @(posedge i_clk); while (!o_in_ready);
        n_req++;
        predict_request(restart, typed, tres);
    endtask

    // write the order register only while the core is idle
    task automatic write_order(input logic [cas_pkg::CAS_ORDER_W-1:0] v);
        i_in_valid <= 1'b0;
        wait (solution_q.size() == 0);
        repeat (24) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_order <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mdl_order = v;
        restart_search();
        n_cfg++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold-off, field checks
    // ------------------------------------------------------------------
    int  stall_left = 0;
    bit  held_long  = 0;

    always @(posedge i_clk) begin
        t_elem got;
        t_elem want;
        if (o_out_valid && i_out_ready) begin
            got = '{pos: o_position, val: o_value, last: o_last, exh: o_exhausted};
            n_res++;
            if (o_exhausted) n_exh++;
            if (solution_q.size() == 0) begin
                $display("%0t: unexpected result pos=%0d val=%0d last=%0b exh=%0b",
                         $time, got.pos, got.val, got.last, got.exh);
                errors++;
            end else begin
                want = solution_q.pop_front();
                if (got.pos !== want.pos) begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.pos, got.pos);
                    errors++;
                end
                if (got.val !== want.val) begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, want.val, got.val);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, got.last);
                    errors++;
                end
                if (got.exh !== want.exh) begin
                    $display("%0t: exhausted expected %0b actual %0b",
                             $time, want.exh, got.exh);
                    errors++;
                end
            end
        end
        // hold off once for a long stretch so the core backs up its input
        if (!held_long && n_res >= 300) begin
            held_long  = 1;
            stall_left = 500;
        end
        if (quiet && stall_left > 40) stall_left = 0;
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any transfer
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_MAX) begin
            $display("%0t: watchdog expired, %0d results pending", $time,
                     solution_q.size());
            $display("costas_array_search_core_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    localparam t_elem R_ONE = '{pos: 4'd0, val: 4'd0, last: 1'b1, exh: 1'b0};
    localparam t_elem R_EXH = '{pos: 4'd0, val: 4'd0, last: 1'b1, exh: 1'b1};
    localparam t_elem R_NONE = '{pos: 4'd0, val: 4'd0, last: 1'b0, exh: 1'b0};

    t_row dir_rows [] = '{
        '{1, 5'd1,  1, 0, 1, R_ONE},   // order 1: the single element
        '{0, 5'd0,  1, 0, 1, R_EXH},   // then exhausted
        '{0, 5'd0,  1, 0, 1, R_EXH},   // resume after exhaustion repeats it
        '{0, 5'd0,  1, 1, 1, R_ONE},   // restart brings the solution back
        '{1, 5'd0,  1, 0, 1, R_ONE},   // order zero acts as order one
        '{1, 5'd2,  1, 0, 0, R_NONE},
        '{0, 5'd0,  1, 0, 0, R_NONE},
        '{0, 5'd0,  1, 0, 1, R_EXH},
        '{1, 5'd3,  1, 1, 0, R_NONE},
        '{0, 5'd0,  1, 0, 0, R_NONE},
        '{0, 5'd0,  1, 0, 0, R_NONE},
        '{0, 5'd0,  1, 0, 0, R_NONE},
        '{0, 5'd0,  1, 0, 1, R_EXH},
        '{1, 5'd16, 0, 0, 0, R_NONE},  // largest order: write only
        '{1, 5'd31, 0, 0, 0, R_NONE},  // above range: write only
        '{1, 5'd5,  1, 0, 0, R_NONE},
        '{0, 5'd0,  1, 0, 0, R_NONE},
        '{0, 5'd0,  1, 1, 0, R_NONE},
        '{0, 5'd0,  1, 0, 0, R_NONE},
        '{1, 5'd6,  1, 0, 0, R_NONE},
        '{0, 5'd0,  1, 0, 0, R_NONE},
        '{1, 5'd8,  1, 1, 0, R_NONE}
    };

    initial begin
        int left;
        int burst;
        int pick;
        logic [cas_pkg::CAS_ORDER_W-1:0] ord;

        mdl_order = cas_pkg::CAS_ORDER_RESET;
        restart_search();

        // hold reset at the start, then release at an edge
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].do_cfg) write_order(dir_rows[r].cfg_val);
            if (dir_rows[r].do_req)
                send_request(dir_rows[r].restart, dir_rows[r].typed,
                             dir_rows[r].typed_res);
        end

        // random phases: mostly small orders, now and then 8 to 10
        left = RND_REQS;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                ord   = 5'($urandom_range(1, 7));
                burst = $urandom_range(1, 40);
            end else if (pick < 95) begin
                ord   = 5'($urandom_range(8, 9));
                burst = $urandom_range(1, 10);
            end else begin
                ord   = 5'd10;
                burst = $urandom_range(1, 4);
            end
            write_order(ord);
            for (int k = 0; k < burst && left > 0; k++) begin
                if (left < 60) quiet = 1;
                send_request($urandom_range(0, 9) == 0, 0, R_NONE);
                left--;
            end
        end
        i_in_valid <= 1'b0;

        // drain and let the core settle
        wait (solution_q.size() == 0);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d requests, %0d result transfers, %0d exhausted, %0d order writes,",
                 n_req, n_res, n_exh, n_cfg);
        $display("largest solved order %0d, %0d mismatches.", n_sol_max, errors);
        if (errors == 0) begin
            $display("costas_array_search_core_tb OK");
        end else begin
            $display("costas_array_search_core_tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/cas_pkg.sv
hw/rtl/cas_perm_mem.sv
hw/rtl/cas_diff_mem.sv
hw/rtl/costas_array_search_core.sv
tb/costas_array_search_core_tb.sv
